// File: sv/i2cms_pkg.sv
// Shared types, codes and the phase table of the I2C master byte sequencer.
// Used by every module of the block; depends on nothing.
package i2cms_pkg;

    localparam int DELAY_W = 16;
    localparam logic [DELAY_W-1:0] PHASE_DELAY_RESET = 16'd50;

    localparam int PH_W = 5;
    localparam logic [PH_W-1:0] WRITE_LAST_PH = 5'd24;
    localparam logic [PH_W-1:0] READ_LAST_PH  = 5'd16;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ      = 3'd3,
        OP_RD_ACK    = 3'd4,
        OP_SEND_ACK  = 3'd5,
        OP_SEND_NACK = 3'd6
    } op_t;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BUS_BUSY   = 2'd1;
    localparam logic [1:0] STAT_START_FAIL = 2'd2;
    localparam logic [1:0] STAT_NACK       = 2'd3;

    typedef struct packed {
        op_t        op;
        logic [7:0] wbyte;
        logic [7:0] smp;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] rdata;
        logic       sda;
        logic       scl;
        logic       last;
    } phase_t;

    typedef struct packed {
        logic load;
        logic pop;
    } back_stat_t;

    // Line levels and flags of phase ph of a command. sub and bit_val are the
    // position inside a data bit and the bit being sent by a write.
    function automatic phase_t phase_gen(cmd_t cmd, logic [PH_W-1:0] ph, logic [1:0] sub,
                                         logic bit_val, logic sda_prev);
        phase_t p;
        logic   first;
        logic   lvl;
        p     = '0;
        first = cmd.smp[7];
        lvl   = (cmd.op == OP_SEND_NACK);
        unique case (cmd.op)
            OP_START:
            begin
                if (ph == 5'd0)
                begin
                    p.scl    = 1'b1;
                    p.sda    = 1'b1;
                    p.status = first ? STAT_OK : STAT_BUS_BUSY;
                    p.last   = !first;
                end
                else if (ph == 5'd1)
                begin
                    p.scl = 1'b1;
                    if (cmd.smp[6])
                    begin
                        p.status = STAT_START_FAIL;
                        p.last   = 1'b1;
                    end
                end
                else
                begin
                    p.last = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (ph == 5'd0)
                    p.sda = sda_prev;
                else if (ph == 5'd2)
                    p.scl = 1'b1;
                else if (ph != 5'd1)
                begin
                    p.scl  = 1'b1;
                    p.sda  = 1'b1;
                    p.last = 1'b1;
                end
            end
            OP_WRITE:
            begin
                if (ph == WRITE_LAST_PH)
                begin
                    p.sda  = sda_prev;
                    p.last = 1'b1;
                end
                else if (sub == 2'd0)
                    p.sda = sda_prev;
                else
                begin
                    p.sda = bit_val;
                    p.scl = (sub == 2'd2);
                end
            end
            OP_READ:
            begin
                p.sda = 1'b1;
                if (ph == READ_LAST_PH)
                begin
                    p.rdata = cmd.smp;
                    p.last  = 1'b1;
                end
                else
                    p.scl = ph[0];
            end
            OP_RD_ACK:
            begin
                p.sda = 1'b1;
                if (ph == 5'd1)
                    p.scl = 1'b1;
                else if (ph != 5'd0)
                begin
                    p.status = first ? STAT_NACK : STAT_OK;
                    p.last   = 1'b1;
                end
            end
            OP_SEND_ACK, OP_SEND_NACK:
            begin
                if (ph == 5'd0)
                    p.sda = sda_prev;
                else
                begin
                    p.sda  = lvl;
                    p.scl  = (ph == 5'd2);
                    p.last = (ph != 5'd1) && (ph != 5'd2);
                end
            end
            default:
            begin
                p.last = 1'b1;
            end
        endcase
        return p;
    endfunction

endpackage

// File: sv/i2cms_front.sv
// Front stage: takes command beats, drops undefined operation codes and
// hands decoded commands to the queue. Depends on i2cms_pkg.
module i2cms_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2cms_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               push,
    output i2cms_pkg::cmd_t                    push_cmd,
    input  logic                               q_full
);
    import i2cms_pkg::*;

    logic vld_reg;
    logic vld_next;
    cmd_t cmd_reg;
    logic legal;
    logic take;

    assign legal    = (s_tdata[2:0] <= OP_SEND_NACK);
    assign push     = vld_reg && !q_full;
    assign s_tready = !vld_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
            vld_next = legal;
        else if (push)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg.op    <= op_t'(s_tdata[2:0]);
            cmd_reg.wbyte <= s_tdata[10:3];
            cmd_reg.smp   <= s_tdata[18:11];
        end
    end

endmodule

// File: sv/i2cms_cmd_fifo.sv
// Short command queue between the front stage and the phase sequencer.
// Depends on i2cms_pkg.
module i2cms_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  i2cms_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output logic              head_valid,
    output i2cms_pkg::cmd_t   head,
    output logic              full,
    output logic              empty
);
    import i2cms_pkg::*;

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] cnt_reg;

    assign empty      = (cnt_reg == '0);
    assign full       = (cnt_reg == Q_CW'(Q_DEPTH));
    assign head_valid = !empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: sv/i2cms_back.sv
// Phase sequencer: walks the queued command through its line phases, holds
// each phase for the configured delay and drives the result register.
// Depends on i2cms_pkg.
module i2cms_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [i2cms_pkg::DELAY_W-1:0]       phase_delay,
    input  logic                                head_valid,
    input  i2cms_pkg::cmd_t                     head,
    output i2cms_pkg::back_stat_t               stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast
);
    import i2cms_pkg::*;

    logic [PH_W-1:0]    ph_reg;
    logic [1:0]         sub_reg;
    logic [2:0]         bit_reg;
    logic               sda_drive_reg;
    logic [DELAY_W-1:0] wait_reg;
    logic               out_vld_reg;
    phase_t             out_reg;
    phase_t             p;
    logic               bit_val;
    logic               load;

    assign bit_val = head.wbyte[3'd7 - bit_reg];
    assign p       = phase_gen(head, ph_reg, sub_reg, bit_val, sda_drive_reg);
    assign load    = head_valid && (wait_reg == '0) && (!out_vld_reg || m_tready);

    assign stat.load = load;
    assign stat.pop  = load && p.last;

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'b0000, out_reg.status, out_reg.rdata, out_reg.sda, out_reg.scl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= '0;
            sub_reg       <= '0;
            bit_reg       <= '0;
            sda_drive_reg <= 1'b1;
            wait_reg      <= '0;
            out_vld_reg   <= 1'b0;
        end
        else if (load)
        begin
            out_vld_reg   <= 1'b1;
            sda_drive_reg <= p.sda;
            wait_reg      <= phase_delay - 1'b1;
            if (p.last)
            begin
                ph_reg  <= '0;
                sub_reg <= '0;
                bit_reg <= '0;
            end
            else
            begin
                ph_reg <= ph_reg + 1'b1;
                if (sub_reg == 2'd2)
                begin
                    sub_reg <= '0;
                    bit_reg <= bit_reg + 1'b1;
                end
                else
                    sub_reg <= sub_reg + 1'b1;
            end
        end
        else
        begin
            if (m_tready)
                out_vld_reg <= 1'b0;
            if (wait_reg != '0)
                wait_reg <= wait_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= p;
    end

endmodule

// File: sv/i2c_master_byte_sequencer_core.sv
// Top level of the I2C master byte sequencer: configuration register, front
// stage, command queue and phase sequencer. Depends on i2cms_pkg and the i2cms_* modules.
//
//  Channel   Direction  Handshake             Payload
//  s_*       in         s_tvalid / s_tready   one bus command per beat
//  m_*       out        m_tvalid / m_tready   one line phase per beat, m_tlast on the final one
//  cfg_*     in         cfg_valid / cfg_ready phase_delay, 16 bits
//
// A command expands into 1 to 25 phase beats, a write byte into 25. After a phase
// is loaded into the output register the sequencer waits for the phase timer,
// loaded from phase_delay, to run out before it loads the next phase.
// Reset sets phase_delay to 50, empties the queue and releases SDA.
// A stalled result consumer stops the sequencer at the output register, and
// the front stage and two-entry queue keep taking commands until they fill.
module i2c_master_byte_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] operation, [10:3] write_byte, [18:11] sda_samples, [23:19] zero
    input  logic [i2cms_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_level, [1] sda_level, [9:2] read_data, [11:10] status, [15:12] zero
    output logic [i2cms_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2cms_pkg::DELAY_W-1:0]       cfg_data
);
    import i2cms_pkg::*;

    logic [DELAY_W-1:0] phase_delay_reg;
    logic               push;
    cmd_t               push_cmd;
    logic               q_full;
    logic               q_empty;
    logic               head_valid;
    cmd_t               head;
    back_stat_t         bstat;

    // Writes are always taken; the user must issue them only while the block is idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_delay_reg <= PHASE_DELAY_RESET;
        else if (cfg_valid)
            phase_delay_reg <= cfg_data;
    end

    // The front stage registers each command beat and filters undefined codes.
    i2cms_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // The queue lets the front keep accepting while the sequencer is busy.
    i2cms_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (bstat.pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // The sequencer retires the head command when its final phase is loaded.
    i2cms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_delay (phase_delay_reg),
        .head_valid  (head_valid),
        .head        (head),
        .stat        (bstat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // A phase is only generated from a queued command.
    a_load_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.load |-> head_valid)
        else $error("phase loaded with an empty queue");

    // The queue cannot be full and empty at once.
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty together");

    // Error and ack statuses only appear on the final phase of a command.
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[11:10] != STAT_OK)) |-> m_tlast)
        else $error("nonzero status on a phase that is not final");

endmodule
